// ----- rtl/stl_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Source text lexer package
// Token kinds, scan modes, keyword spellings and the result record shared by
// the lexer logic.
// ----------------------------------------------------------------------------
package stl_pkg;

  localparam int unsigned KW_COUNT = 13;

  localparam logic [15:0] LINE_LIMIT      = 16'hFFFF;
  localparam logic [15:0] TOKEN_LEN_LIMIT = 16'hFFFF;
  localparam logic [19:0] OFFSET_LIMIT    = 20'hFFFFF;

  localparam logic [3:0] M_IDLE    = 4'd0;
  localparam logic [3:0] M_IDENT   = 4'd1;
  localparam logic [3:0] M_NUMBER  = 4'd2;
  localparam logic [3:0] M_BANG    = 4'd3;
  localparam logic [3:0] M_EQ      = 4'd4;
  localparam logic [3:0] M_LT      = 4'd5;
  localparam logic [3:0] M_GT      = 4'd6;
  localparam logic [3:0] M_SLASH   = 4'd7;
  localparam logic [3:0] M_COMMENT = 4'd8;

  localparam logic [5:0] K_END     = 6'd0;
  localparam logic [5:0] K_IDENT   = 6'd1;
  localparam logic [5:0] K_INT     = 6'd2;
  localparam logic [5:0] K_LPAREN  = 6'd14;
  localparam logic [5:0] K_RPAREN  = 6'd15;
  localparam logic [5:0] K_LBRACE  = 6'd16;
  localparam logic [5:0] K_RBRACE  = 6'd17;
  localparam logic [5:0] K_COMMA   = 6'd18;
  localparam logic [5:0] K_COLON   = 6'd19;
  localparam logic [5:0] K_SEMI    = 6'd20;
  localparam logic [5:0] K_LBRACK  = 6'd21;
  localparam logic [5:0] K_RBRACK  = 6'd22;
  localparam logic [5:0] K_PLUS    = 6'd23;
  localparam logic [5:0] K_MINUS   = 6'd24;
  localparam logic [5:0] K_STAR    = 6'd25;
  localparam logic [5:0] K_PERCENT = 6'd26;
  localparam logic [5:0] K_BANG    = 6'd27;
  localparam logic [5:0] K_NE      = 6'd28;
  localparam logic [5:0] K_ASSIGN  = 6'd29;
  localparam logic [5:0] K_EQ      = 6'd30;
  localparam logic [5:0] K_LT      = 6'd31;
  localparam logic [5:0] K_LE      = 6'd32;
  localparam logic [5:0] K_GT      = 6'd33;
  localparam logic [5:0] K_GE      = 6'd34;
  localparam logic [5:0] K_SLASH   = 6'd35;
  localparam logic [5:0] K_ERROR   = 6'd36;

  // Spellings are right-justified: the last character sits in bits 7:0.
  localparam logic [79:0] KW_STR [KW_COUNT] = '{
    80'("funcao"), 80'("variavel"), 80'("var"), 80'("retorna"), 80'("retorne"),
    80'("se"), 80'("senao"), 80'("enquanto"), 80'("inteiro"), 80'("logico"),
    80'("vazio"), 80'("verdadeiro"), 80'("falso")
  };
  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd6, 4'd8, 4'd3, 4'd7, 4'd7, 4'd2, 4'd5, 4'd8, 4'd7, 4'd6, 4'd5, 4'd10, 4'd5
  };
  localparam logic [5:0] KW_KIND [KW_COUNT] = '{
    6'd3, 6'd4, 6'd4, 6'd5, 6'd5, 6'd6, 6'd7, 6'd8, 6'd9, 6'd10, 6'd11, 6'd12, 6'd13
  };

  typedef struct packed {
    logic [5:0]  kind;
    logic [15:0] line;
    logic [15:0] column;
    logic [19:0] offset;
    logic [15:0] length;
    logic        last;
  } tok_t;

  function automatic logic [7:0] kw_char(input int unsigned k, input logic [3:0] idx);
    logic [3:0] sh;
    logic [79:0] s;
    sh = KW_LEN[k] - idx - 4'd1;
    s = KW_STR[k] >> {sh, 3'b000};
    return s[7:0];
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

endpackage

// ----- rtl/source_text_lexer_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Source text lexer
// Takes one text byte per transfer and emits tokens with their start position
// and length through a four-entry result queue.
// A token is queued as the byte that ends it is taken, and can leave in the following cycle at the earliest.
// Throughput: one byte per cycle; a byte that ends two tokens puts two results
// in the queue, and the input stalls while fewer than two entries are free.
// Reset clears the scan state, the position counters and the result queue.
// ----------------------------------------------------------------------------
module source_text_lexer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  text_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [5:0]  token_kind_o,
  output logic [15:0] start_line_o,
  output logic [15:0] start_column_o,
  output logic [19:0] start_offset_o,
  output logic [15:0] token_length_o,
  output logic        last_of_run_o
);
  import stl_pkg::*;

  logic [3:0]          mode_q, mode_d;
  logic [KW_COUNT-1:0] mask_q, mask_d;
  logic [15:0]         plen_q, plen_d;
  logic [19:0]         poff_q, poff_d;
  logic [15:0]         pline_q, pline_d;
  logic [15:0]         pcol_q, pcol_d;
  logic [15:0]         cline_q, cline_d;
  logic [15:0]         ccol_q, ccol_d;
  logic [19:0]         coff_q, coff_d;

  tok_t       fifo_q [4];
  logic [1:0] wr_ptr_q, rd_ptr_q;
  logic [2:0] cnt_q, cnt_d;
  logic       in_fire, out_fire;

  logic                va, vb;
  logic [5:0]          ka, kb;
  logic [15:0]         la, lb;
  logic                flush_v;
  logic [5:0]          flush_kind;
  logic [5:0]          id_kind;
  logic [KW_COUNT-1:0] first_mask, next_mask;
  tok_t                r0, r1;
  logic [1:0]          n_push;

  always_comb begin
    first_mask = '0;
    next_mask  = '0;
    id_kind    = K_IDENT;
    for (int k = KW_COUNT - 1; k >= 0; k--) begin
      first_mask[k] = kw_char(k, 4'd0) == text_byte_i;
      next_mask[k]  = mask_q[k] && (plen_q < {12'd0, KW_LEN[k]}) &&
                      (kw_char(k, plen_q[3:0]) == text_byte_i);
      if (mask_q[k] && plen_q == {12'd0, KW_LEN[k]}) begin
        id_kind = KW_KIND[k];
      end
    end
  end

  always_comb begin
    flush_v    = 1'b1;
    flush_kind = K_IDENT;
    unique case (mode_q)
      M_IDENT:  flush_kind = id_kind;
      M_NUMBER: flush_kind = K_INT;
      M_BANG:   flush_kind = K_BANG;
      M_EQ:     flush_kind = K_ASSIGN;
      M_LT:     flush_kind = K_LT;
      M_GT:     flush_kind = K_GT;
      M_SLASH:  flush_kind = K_SLASH;
      default:  flush_v = 1'b0;
    endcase
  end

  always_comb begin
    logic fresh;
    fresh   = 1'b0;
    mode_d  = mode_q;
    mask_d  = mask_q;
    plen_d  = plen_q;
    poff_d  = poff_q;
    pline_d = pline_q;
    pcol_d  = pcol_q;
    cline_d = cline_q;
    ccol_d  = ccol_q;
    coff_d  = coff_q;
    va = 1'b0;
    vb = 1'b0;
    ka = flush_kind;
    kb = K_END;
    la = plen_q;
    lb = 16'd0;

    if (text_byte_i == 8'd0) begin
      va      = flush_v;
      vb      = 1'b1;
      mode_d  = M_IDLE;
      mask_d  = '0;
      cline_d = 16'd1;
      ccol_d  = 16'd1;
      coff_d  = 20'd0;
    end else begin
      unique case (mode_q)
        M_IDENT: begin
          if (is_alpha(text_byte_i) || is_digit(text_byte_i)) begin
            mask_d = next_mask;
            plen_d = (plen_q != TOKEN_LEN_LIMIT) ? plen_q + 16'd1 : plen_q;
          end else begin
            fresh = 1'b1;
          end
        end
        M_NUMBER: begin
          if (is_digit(text_byte_i)) begin
            plen_d = (plen_q != TOKEN_LEN_LIMIT) ? plen_q + 16'd1 : plen_q;
          end else begin
            fresh = 1'b1;
          end
        end
        M_BANG, M_EQ, M_LT, M_GT: begin
          if (text_byte_i == "=") begin
            va     = 1'b1;
            la     = 16'd2;
            plen_d = 16'd2;
            mode_d = M_IDLE;
            unique case (mode_q)
              M_BANG:  ka = K_NE;
              M_EQ:    ka = K_EQ;
              M_LT:    ka = K_LE;
              default: ka = K_GE;
            endcase
          end else begin
            fresh = 1'b1;
          end
        end
        M_SLASH: begin
          if (text_byte_i == "/") begin
            mode_d = M_COMMENT;
          end else begin
            fresh = 1'b1;
          end
        end
        M_COMMENT: begin
          if (text_byte_i == "\n") begin
            mode_d = M_IDLE;
          end
        end
        default: fresh = 1'b1;
      endcase

      if (fresh) begin
        va     = flush_v;
        mode_d = M_IDLE;
        mask_d = '0;
        lb     = 16'd1;
        if (is_alpha(text_byte_i)) begin
          mode_d = M_IDENT;
          mask_d = first_mask;
        end else if (is_digit(text_byte_i)) begin
          mode_d = M_NUMBER;
        end else begin
          vb = 1'b1;
          unique case (text_byte_i)
            " ", "\t", "\r", "\n": vb = 1'b0;
            "(": kb = K_LPAREN;
            ")": kb = K_RPAREN;
            "{": kb = K_LBRACE;
            "}": kb = K_RBRACE;
            ",": kb = K_COMMA;
            ":": kb = K_COLON;
            ";": kb = K_SEMI;
            "[": kb = K_LBRACK;
            "]": kb = K_RBRACK;
            "+": kb = K_PLUS;
            "-": kb = K_MINUS;
            "*": kb = K_STAR;
            "%": kb = K_PERCENT;
            "!": begin vb = 1'b0; mode_d = M_BANG; end
            "=": begin vb = 1'b0; mode_d = M_EQ; end
            "<": begin vb = 1'b0; mode_d = M_LT; end
            ">": begin vb = 1'b0; mode_d = M_GT; end
            "/": begin vb = 1'b0; mode_d = M_SLASH; end
            default: kb = K_ERROR;
          endcase
        end
        if (mode_d != M_IDLE) begin
          plen_d  = 16'd1;
          poff_d  = coff_q;
          pline_d = cline_q;
          pcol_d  = ccol_q;
        end
      end

      if (text_byte_i == "\n") begin
        cline_d = (cline_q != LINE_LIMIT) ? cline_q + 16'd1 : cline_q;
        ccol_d  = 16'd1;
      end else begin
        ccol_d = (ccol_q != LINE_LIMIT) ? ccol_q + 16'd1 : ccol_q;
      end
      coff_d = (coff_q != OFFSET_LIMIT) ? coff_q + 20'd1 : coff_q;
    end
  end

  always_comb begin
    tok_t ta, tb;
    ta = '{kind: ka, line: pline_q, column: pcol_q, offset: poff_q, length: la,
           last: !vb};
    tb = '{kind: kb, line: cline_q, column: ccol_q, offset: coff_q, length: lb,
           last: 1'b1};
    r0 = va ? ta : tb;
    r1 = tb;
    n_push = in_fire ? ({1'b0, va} + {1'b0, vb}) : 2'd0;
  end

  assign in_ready_o  = cnt_q <= 3'd2;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = cnt_q != 3'd0;
  assign out_fire    = out_valid_o && out_ready_i;
  assign cnt_d       = cnt_q + {1'b0, n_push} - {2'b00, out_fire};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= M_IDLE;
      mask_q   <= '0;
      plen_q   <= 16'd0;
      poff_q   <= 20'd0;
      pline_q  <= 16'd1;
      pcol_q   <= 16'd1;
      cline_q  <= 16'd1;
      ccol_q   <= 16'd1;
      coff_q   <= 20'd0;
      wr_ptr_q <= 2'd0;
      rd_ptr_q <= 2'd0;
      cnt_q    <= 3'd0;
    end else begin
      if (in_fire) begin
        mode_q  <= mode_d;
        mask_q  <= mask_d;
        plen_q  <= plen_d;
        poff_q  <= poff_d;
        pline_q <= pline_d;
        pcol_q  <= pcol_d;
        cline_q <= cline_d;
        ccol_q  <= ccol_d;
        coff_q  <= coff_d;
      end
      wr_ptr_q <= wr_ptr_q + n_push;
      if (out_fire) begin
        rd_ptr_q <= rd_ptr_q + 2'd1;
      end
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) begin
      fifo_q[wr_ptr_q] <= r0;
    end
    if (n_push == 2'd2) begin
      fifo_q[wr_ptr_q + 2'd1] <= r1;
    end
  end

  assign token_kind_o   = fifo_q[rd_ptr_q].kind;
  assign start_line_o   = fifo_q[rd_ptr_q].line;
  assign start_column_o = fifo_q[rd_ptr_q].column;
  assign start_offset_o = fifo_q[rd_ptr_q].offset;
  assign token_length_o = fifo_q[rd_ptr_q].length;
  assign last_of_run_o  = fifo_q[rd_ptr_q].last;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'd4)
    else $error("result queue count out of range");

  a_mask_only_ident: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q != M_IDENT |-> mask_q == '0)
    else $error("keyword mask live outside an identifier");

  a_pending_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == M_IDENT || mode_q == M_NUMBER) |-> plen_q != 16'd0)
    else $error("pending token has zero length");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i && !in_fire) |=> cnt_q == $past(cnt_q))
    else $error("result queue changed while stalled on both sides");

endmodule
